@@ src/gcu_pkg.sv @@
// Shared types for the GCD/LCM unit: sequencer states and the status
// bundle that the iterative units report to the sequencer. No dependencies.
`default_nettype none

package gcu_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL
    } gcu_state_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } gcu_status_t;

endpackage

`default_nettype wire

@@ src/gcu_gcd.sv @@
// Iterative binary GCD: one shift or subtract-and-shift step per cycle.
// Depends on gcu_pkg for the status bundle.
`default_nettype none

module gcu_gcd #(
    parameter int W = 30
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [W-1:0]        a_in,
    input  wire logic [W-1:0]        b_in,
    output gcu_pkg::gcu_status_t     status,
    output logic      [W-1:0]        result
);
    import gcu_pkg::*;

    localparam int KW = $clog2(W + 1);

    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [W-1:0]  result_reg, result_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    diff_ab;
    logic [W-1:0]  diff_ba;

    assign diff_ab = {1'b0, a_reg} - {1'b0, b_reg};
    assign diff_ba = b_reg - a_reg;

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        result_next = result_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (a_reg == '0)
            begin
                result_next = b_reg << k_reg;
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
            else if (b_reg == '0)
            begin
                result_next = a_reg << k_reg;
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                case ({a_reg[0], b_reg[0]})
                    2'b00:
                    begin
                        // common factor of two: strip from both, count it
                        a_next = a_reg >> 1;
                        b_next = b_reg >> 1;
                        k_next = k_reg + 1'b1;
                    end
                    2'b01:
                    begin
                        a_next = a_reg >> 1;
                    end
                    2'b10:
                    begin
                        b_next = b_reg >> 1;
                    end
                    default:
                    begin
                        // both odd: difference is even, halve it at once
                        if (diff_ab[W])
                            b_next = diff_ba >> 1;
                        else
                            a_next = diff_ab[W-1:0] >> 1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result      = result_reg;

endmodule

`default_nettype wire

@@ src/gcu_div.sv @@
// Restoring divider: one quotient bit per cycle, W quotient bits per division.
// Depends on gcu_pkg for the status bundle.
`default_nettype none

module gcu_div #(
    parameter int W = 30
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [W-1:0]        dividend,
    input  wire logic [W-1:0]        denom,
    output gcu_pkg::gcu_status_t     status,
    output logic      [W-1:0]        quotient
);
    import gcu_pkg::*;

    localparam int            CW    = $clog2(W + 1);
    localparam logic [CW-1:0] STEPS = CW'(W);
    localparam logic [CW-1:0] LAST  = CW'(1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W+1:0]  trial;
    logic          borrow;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign borrow  = trial[W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = denom;
            cnt_next  = STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restore on borrow: keep the shifted remainder as it was
            rem_next = borrow ? shifted[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], ~borrow};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

@@ src/gcd_lcm_unit.sv @@
// Top level of the GCD/LCM unit: sequencer, final multiply, output register.
// Depends on gcu_pkg, gcu_gcd and gcu_div.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------
//   in      | in_valid  | in_stall  | first_value, second_value
//   out     | out_valid | out_stall | divisor, multiple
//
// One item: a load, up to 2*OPERAND_WIDTH binary-GCD steps plus a done step,
// OPERAND_WIDTH divider steps plus a done step (skipped on a zero operand), a multiply.
// in_stall is high from acceptance until the result moves to the output register.
// The output register frees the next item to start while a result waits.
// Reset clears the sequencer and the output valid; the data registers are not reset.
`default_nettype none

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = 30
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [OPERAND_WIDTH-1:0]     first_value,
    input  wire logic [OPERAND_WIDTH-1:0]     second_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [OPERAND_WIDTH-1:0]     divisor,
    output logic      [2*OPERAND_WIDTH-1:0]   multiple
);
    import gcu_pkg::*;

    localparam int W = OPERAND_WIDTH;

    gcu_state_t       state_reg, state_next;
    logic [W-1:0]     a_reg, b_reg;
    logic             zero_reg;
    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     divisor_reg;
    logic [2*W-1:0]   multiple_reg;

    logic             in_take;
    logic             out_free;
    logic             div_start;
    logic             load_out;
    gcu_status_t      gcd_status;
    gcu_status_t      div_status;
    logic [W-1:0]     gcd_result;
    logic [W-1:0]     quotient;
    logic [2*W-1:0]   product;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    gcu_gcd #(.W(W)) u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_take),
        .a_in   (first_value),
        .b_in   (second_value),
        .status (gcd_status),
        .result (gcd_result)
    );

    gcu_div #(.W(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .denom    (gcd_result),
        .status   (div_status),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (gcd_status.done)
                    state_next = zero_reg ? ST_MUL : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_GCD:
            begin
                div_start = gcd_status.done && !zero_reg;
            end
            ST_MUL:
            begin
                load_out = out_free;
            end
            default:
            begin
                div_start = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    // lcm = (a / gcd) * b; zero when either operand is zero
    assign product = zero_reg ? '0 : ({{W{1'b0}}, quotient} * {{W{1'b0}}, b_reg});

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg    <= first_value;
            b_reg    <= second_value;
            zero_reg <= (first_value == '0) || (second_value == '0);
        end
        if (load_out)
        begin
            divisor_reg  <= gcd_result;
            multiple_reg <= product;
        end
    end

    assign out_valid = out_valid_reg;
    assign divisor   = divisor_reg;
    assign multiple  = multiple_reg;

    a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_status.done |-> state_reg == ST_GCD)
        else $error("GCD finished outside its sequencer state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its sequencer state");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> gcd_result != '0)
        else $error("divider started with a zero divisor");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && out_valid_reg && out_stall) |=> state_reg == ST_MUL)
        else $error("result overwrote a pending transfer");

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !gcd_status.busy && !div_status.busy)
        else $error("sequencer idle while a unit is still busy");

endmodule

`default_nettype wire

@@ bench/gcd_lcm_unit_tb.sv @@
// Testbench for gcd_lcm_unit: drives operand pairs over the valid/stall input
// and checks each divisor and multiple against a Euclid-based predictor.
// Depends only on the RTL of gcd_lcm_unit.
`default_nettype none

module gcd_lcm_unit_tb;

    localparam int OPW = 30;
    localparam int RESULT_W = 2 * OPW;
    localparam logic [OPW-1:0] OP_MAX = '1;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned HOLD_CYCLES = 2000;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic [OPW-1:0]      divisor;
        logic [RESULT_W-1:0] multiple;
    } gcd_lcm_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OPW-1:0]      first_value = '0;
    logic [OPW-1:0]      second_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [OPW-1:0]      divisor;
    logic [RESULT_W-1:0] multiple;

    gcd_lcm_t    pending_results[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          offering = 1'b0;
    bit          calm = 1'b0;
    bit          hold_request = 1'b0;

    gcd_lcm_unit #(
        .OPERAND_WIDTH (OPW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_value  (first_value),
        .second_value (second_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .divisor      (divisor),
        .multiple     (multiple)
    );

    always #5 clk = ~clk;

    function automatic gcd_lcm_t predict_gcd_lcm(input logic [OPW-1:0] a,
                                                 input logic [OPW-1:0] b);
        logic [RESULT_W-1:0] x;
        logic [RESULT_W-1:0] y;
        logic [RESULT_W-1:0] r;
        gcd_lcm_t res;
        x = RESULT_W'(a);
        y = RESULT_W'(b);
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        res.divisor = x[OPW-1:0];
        // a zero operand gives a zero multiple and no division
        if (a != 0 && b != 0)
            res.multiple = (RESULT_W'(a) / x) * RESULT_W'(b);
        else
            res.multiple = '0;
        return res;
    endfunction

    function automatic logic [OPW-1:0] low_mask(input int unsigned width);
        logic [OPW-1:0] m;
        m = '1;
        return m >> (OPW - width);
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [OPW-1:0] random_operand();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return '0;
        if (roll < 75)
            return OPW'($urandom);
        return OPW'($urandom) & low_mask($urandom_range(1, OPW));
    endfunction

    task automatic send_operands(input logic [OPW-1:0] a, input logic [OPW-1:0] b);
        int unsigned gap;
        gap = pick_idle();
        if (gap != 0)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        first_value <= a;
        second_value <= b;
        if (!offering)
        begin
            in_valid <= 1'b1;
            offering = 1'b1;
        end
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_gcd_lcm(a, b));
    endtask

    task automatic drop_input();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_operands(1, 1);
        send_operands(OP_MAX, OP_MAX);
        send_operands(1, OP_MAX);
        send_operands(OP_MAX, 1);
        send_operands(0, 0);
        send_operands(0, OP_MAX);
        send_operands(OP_MAX, 0);
        send_operands(0, 1);
        send_operands(1, 0);
        send_operands(12, 18);
        send_operands(18, 12);
        send_operands(30'h2000_0000, 30'h1000_0000);
        send_operands(30'h2000_0000, 1);
        send_operands(OP_MAX, OP_MAX - OPW'(1));
        send_operands(30'h2AAA_AAAA, 30'h1555_5555);
        // consecutive Fibonacci numbers: longest remainder chain
        send_operands(701408733, 433494437);
        send_operands(1073741789, 1073741783);
        send_operands(7, 7 * 123456);
        send_operands(12345, 12345);
        send_operands(30'h3FFF_FFFE, 30'h3FFF_FFFC);
    endtask

    task automatic test_random_operands(input int unsigned count);
        repeat (count)
            send_operands(random_operand(), random_operand());
    endtask

    task automatic test_shared_factors(input int unsigned count);
        int unsigned gbits;
        logic [OPW-1:0] common;
        logic [OPW-1:0] x;
        logic [OPW-1:0] y;
        repeat (count)
        begin
            // keep common * cofactor inside the operand width
            gbits = $urandom_range(1, 20);
            common = OPW'($urandom) & low_mask(gbits);
            x = OPW'($urandom) & low_mask(OPW - gbits);
            y = OPW'($urandom) & low_mask($urandom_range(1, OPW - gbits));
            if (common == 0)
                common = 1;
            if (x == 0)
                x = 1;
            if (y == 0)
                y = 1;
            send_operands(common * x, common * y);
        end
    endtask

    task automatic test_small_operands(input int unsigned count);
        repeat (count)
            send_operands(OPW'($urandom_range(0, 64)), OPW'($urandom_range(0, 64)));
    endtask

    task automatic test_output_hold_off(input int unsigned count);
        // receiver holds off while items keep coming, so the input backs up
        hold_request = 1'b1;
        repeat (count)
            send_operands(random_operand(), random_operand());
    endtask

    task automatic test_drain_and_burst(input int unsigned count);
        repeat (count / 2)
            send_operands(random_operand(), random_operand());
        drop_input();
        wait_drained();
        calm = 1'b1;
        repeat (count - count / 2)
            send_operands(random_operand(), random_operand());
        drop_input();
        wait_drained();
        calm = 1'b0;
    endtask

    // receiver: random stalls, a long hold-off on request, none while calm
    initial
    begin
        int unsigned left;
        bit stalling;
        left = 0;
        stalling = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                stalling = 1'b0;
                left = 0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                stalling = 1'b0;
                left = 0;
            end
            else if (left != 0)
                left--;
            else if (stalling)
            begin
                out_stall <= 1'b0;
                stalling = 1'b0;
                left = $urandom_range(0, 30);
            end
            else
            begin
                left = pick_idle();
                if (left != 0)
                begin
                    out_stall <= 1'b1;
                    stalling = 1'b1;
                    left--;
                end
            end
        end
    end

    // compare each transfer on the output against the oldest prediction
    always @(posedge clk)
    begin
        gcd_lcm_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: divisor %0d multiple %0d",
                             divisor, multiple);
            end
            else
            begin
                want = pending_results.pop_front();
                if (divisor !== want.divisor || multiple !== want.multiple)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: divisor exp %0d got %0d, multiple exp %0d got %0d",
                                 want.divisor, divisor, want.multiple, multiple);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL gcd_lcm_unit");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_operands(700);
        test_shared_factors(650);
        test_small_operands(200);
        test_output_hold_off(40);
        test_drain_and_burst(60);
        drop_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS gcd_lcm_unit");
        else
            $display("FAIL gcd_lcm_unit");
        $finish;
    end

endmodule

`default_nettype wire
